>>> hdl/drps_pkg.sv
package drps_pkg;

   // Clip limit for the scan window, applied on top of the frame size.
   localparam int unsigned MAX_DIM = 4096;

   localparam logic [6:0]  THICKNESS_RESET    = 7'd1;
   localparam logic [12:0] IMAGE_WIDTH_RESET  = 13'd640;
   localparam logic [12:0] IMAGE_HEIGHT_RESET = 13'd480;
   localparam logic [12:0] ROW_PITCH_RESET    = 13'd640;

   typedef enum logic [1:0] {
      REG_THICKNESS    = 2'd0,
      REG_IMAGE_WIDTH  = 2'd1,
      REG_IMAGE_HEIGHT = 2'd2,
      REG_ROW_PITCH    = 2'd3
   } reg_index_type;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_STEP   = 1'b1;
   localparam logic KIND_DOT  = 1'b0;
   localparam logic KIND_RING = 1'b1;

   typedef struct packed {
      logic        opcode;
      logic        shape_kind;
      logic [11:0] center_x;
      logic [11:0] center_y;
      logic [11:0] radius;
   } req_type;

   typedef struct packed {
      logic        paint;
      logic [11:0] pixel_x;
      logic [11:0] pixel_y;
      logic [23:0] pixel_address;
      logic        scan_done;
   } rsp_type;

endpackage

>>> hdl/disk_and_ring_pixel_scanner.sv
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_ready  req_data  (drps_pkg::req_type)
// rsp      out        rsp_valid/rsp_ready  rsp_data  (drps_pkg::rsp_type)
// csr      in/out     psel/penable/pready  paddr, pwdata, prdata (APB-style, 32 bits)
//
// One item is accepted per clock unless a held result stalls the pipe; every item gives one
// result item, passing through the two pipeline stages ahead of the result register: the scan
// position update, then the squaring and row-times-pitch multipliers.
// A stalled result freezes the whole pipe; req_ready is low only while the result
// register holds an item that the consumer has not taken.
// Reset (synchronous, active high) empties the pipe, stops any scan and restores the
// register defaults (thickness 1, 640 x 480, pitch 640).
module disk_and_ring_pixel_scanner (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  drps_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output drps_pkg::rsp_type  rsp_data,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam logic signed [14:0] DIM_LIMIT = 15'(drps_pkg::MAX_DIM);

   // Configuration registers
   logic [6:0]  thickness_ff;
   logic [12:0] image_width_ff;
   logic [12:0] image_height_ff;
   logic [12:0] row_pitch_ff;

   // Scan state
   logic        active_ff,      active_in;
   logic [11:0] center_x_ff,    center_x_in;
   logic [11:0] center_y_ff,    center_y_in;
   logic [11:0] scan_x_ff,      scan_x_in;
   logic [11:0] scan_y_ff,      scan_y_in;
   logic [11:0] win_y_first_ff, win_y_first_in;
   logic [11:0] win_x_last_ff,  win_x_last_in;
   logic [11:0] win_y_last_ff,  win_y_last_in;

   // Stage 1: position and distances of the tested pixel, or radii of a load
   logic        s1_valid_ff;
   logic        s1_test_ff,    s1_test_in;
   logic        s1_load_ff,    s1_load_in;
   logic        s1_done_ff,    s1_done_in;
   logic [11:0] s1_x_ff,       s1_x_in;
   logic [11:0] s1_y_ff,       s1_y_in;
   logic [11:0] s1_dx_ff,      s1_dx_in;
   logic [11:0] s1_dy_ff,      s1_dy_in;
   logic [11:0] s1_inner_r_ff, s1_inner_r_in;
   logic [12:0] s1_outer_r_ff, s1_outer_r_in;

   // Stage 2: products
   logic        s2_valid_ff;
   logic        s2_test_ff;
   logic        s2_done_ff;
   logic [11:0] s2_x_ff;
   logic [11:0] s2_y_ff;
   logic [23:0] s2_dx_sq_ff;
   logic [23:0] s2_dy_sq_ff;
   logic [24:0] s2_row_ff;

   // Ring edges of the shape that the items in stage 2 belong to
   logic [25:0] inner_sq_ff;
   logic [25:0] outer_sq_ff;

   // Result register
   logic              rsp_valid_ff;
   drps_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic advance;
   logic accept;
   logic csr_write;
   drps_pkg::reg_index_type csr_index;

   // Load setup
   logic [6:0]         dot_r;
   logic [5:0]         half_w;
   logic [12:0]        ring_outer;
   logic [11:0]        ring_inner;
   logic signed [14:0] lo_off;
   logic signed [14:0] hi_off;
   logic signed [14:0] cx_s;
   logic signed [14:0] cy_s;
   logic signed [14:0] x0;
   logic signed [14:0] y0;
   logic signed [14:0] x1;
   logic signed [14:0] y1;
   logic signed [14:0] x_limit;
   logic signed [14:0] y_limit;
   logic               window_ok;

   // Step
   logic        last_row;
   logic        last_col;
   logic [11:0] dx;
   logic [11:0] dy;

   // Result
   logic [25:0] dist_sq;

   // The whole pipe moves unless the result register is held by the consumer.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign accept    = req_valid && advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------- register port
   assign pready    = 1'b1;
   assign csr_index = drps_pkg::reg_index_type'(paddr[3:2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         thickness_ff    <= drps_pkg::THICKNESS_RESET;
         image_width_ff  <= drps_pkg::IMAGE_WIDTH_RESET;
         image_height_ff <= drps_pkg::IMAGE_HEIGHT_RESET;
         row_pitch_ff    <= drps_pkg::ROW_PITCH_RESET;
      end else if (csr_write) begin
         case (csr_index)
            drps_pkg::REG_THICKNESS:    thickness_ff    <= pwdata[6:0];
            drps_pkg::REG_IMAGE_WIDTH:  image_width_ff  <= pwdata[12:0];
            drps_pkg::REG_IMAGE_HEIGHT: image_height_ff <= pwdata[12:0];
            drps_pkg::REG_ROW_PITCH:    row_pitch_ff    <= pwdata[12:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         drps_pkg::REG_THICKNESS:    prdata = 32'(thickness_ff);
         drps_pkg::REG_IMAGE_WIDTH:  prdata = 32'(image_width_ff);
         drps_pkg::REG_IMAGE_HEIGHT: prdata = 32'(image_height_ff);
         drps_pkg::REG_ROW_PITCH:    prdata = 32'(row_pitch_ff);
         default:                    prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- load setup
   // Dot: radius is the thickness, with 1 widened to 2; window runs from
   // center-R+1 to center+R. Ring: half width is thickness/2, at least 1;
   // window runs from center-r-h to center+r+h.
   always_comb begin
      dot_r      = (thickness_ff == 7'd1) ? 7'd2 : thickness_ff;
      half_w     = (thickness_ff[6:1] == 6'd0) ? 6'd1 : thickness_ff[6:1];
      ring_outer = 13'(req_data.radius) + 13'(half_w);
      // Inner edge at or below zero paints everything out to the outer edge.
      ring_inner = (req_data.radius > 12'(half_w)) ? req_data.radius - 12'(half_w) : '0;

      if (req_data.shape_kind == drps_pkg::KIND_DOT) begin
         lo_off = $signed(15'(dot_r)) - 15'sd1;
         hi_off = $signed(15'(dot_r));
      end else begin
         lo_off = $signed(15'(ring_outer));
         hi_off = $signed(15'(ring_outer));
      end

      cx_s = $signed(15'(req_data.center_x));
      cy_s = $signed(15'(req_data.center_y));

      x0 = cx_s - lo_off;
      y0 = cy_s - lo_off;
      if (x0 < 15'sd0) x0 = '0;
      if (y0 < 15'sd0) y0 = '0;

      x_limit = $signed(15'(image_width_ff));
      y_limit = $signed(15'(image_height_ff));
      if (x_limit > DIM_LIMIT) x_limit = DIM_LIMIT;
      if (y_limit > DIM_LIMIT) y_limit = DIM_LIMIT;

      x1 = cx_s + hi_off;
      y1 = cy_s + hi_off;
      if (x1 > x_limit) x1 = x_limit;
      if (y1 > y_limit) y1 = y_limit;

      window_ok = (x0 < x1) && (y0 < y1);
   end

   // ---------------------------------------------------------------- scan step
   assign last_row = (scan_y_ff == win_y_last_ff);
   assign last_col = (scan_x_ff == win_x_last_ff);
   assign dx = (center_x_ff > scan_x_ff) ? center_x_ff - scan_x_ff : scan_x_ff - center_x_ff;
   assign dy = (center_y_ff > scan_y_ff) ? center_y_ff - scan_y_ff : scan_y_ff - center_y_ff;

   always_comb begin
      active_in      = active_ff;
      center_x_in    = center_x_ff;
      center_y_in    = center_y_ff;
      scan_x_in      = scan_x_ff;
      scan_y_in      = scan_y_ff;
      win_y_first_in = win_y_first_ff;
      win_x_last_in  = win_x_last_ff;
      win_y_last_in  = win_y_last_ff;

      // Untested items carry zero position and distance, so their address is zero.
      s1_test_in    = 1'b0;
      s1_load_in    = 1'b0;
      s1_done_in    = 1'b0;
      s1_x_in       = '0;
      s1_y_in       = '0;
      s1_dx_in      = '0;
      s1_dy_in      = '0;
      s1_inner_r_in = ring_inner;
      s1_outer_r_in = ring_outer;
      if (req_data.shape_kind == drps_pkg::KIND_DOT) begin
         s1_inner_r_in = '0;
         s1_outer_r_in = 13'(dot_r);
      end

      if (req_data.opcode == drps_pkg::OP_LOAD) begin
         s1_load_in  = 1'b1;
         center_x_in = req_data.center_x;
         center_y_in = req_data.center_y;
         active_in   = window_ok;
         s1_done_in  = !window_ok;
         if (window_ok) begin
            scan_x_in      = x0[11:0];
            scan_y_in      = y0[11:0];
            win_y_first_in = y0[11:0];
            win_x_last_in  = 12'(x1 - 15'sd1);
            win_y_last_in  = 12'(y1 - 15'sd1);
         end
      end else if (!active_ff) begin
         // Step with no scan running: report done and nothing else.
         s1_done_in = 1'b1;
      end else begin
         s1_test_in = 1'b1;
         s1_x_in    = scan_x_ff;
         s1_y_in    = scan_y_ff;
         s1_dx_in   = dx;
         s1_dy_in   = dy;
         // Rows run inside columns: advance the row, wrap to the next column.
         if (last_row) begin
            if (last_col) begin
               s1_done_in = 1'b1;
               active_in  = 1'b0;
            end else begin
               scan_x_in = scan_x_ff + 12'd1;
               scan_y_in = win_y_first_ff;
            end
         end else begin
            scan_y_in = scan_y_ff + 12'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else if (accept) begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         center_x_ff    <= center_x_in;
         center_y_ff    <= center_y_in;
         scan_x_ff      <= scan_x_in;
         scan_y_ff      <= scan_y_in;
         win_y_first_ff <= win_y_first_in;
         win_x_last_ff  <= win_x_last_in;
         win_y_last_ff  <= win_y_last_in;
      end
   end

   // ---------------------------------------------------------------- pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= req_valid;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_test_ff    <= s1_test_in;
         s1_load_ff    <= s1_load_in;
         s1_done_ff    <= s1_done_in;
         s1_x_ff       <= s1_x_in;
         s1_y_ff       <= s1_y_in;
         s1_dx_ff      <= s1_dx_in;
         s1_dy_ff      <= s1_dy_in;
         s1_inner_r_ff <= s1_inner_r_in;
         s1_outer_r_ff <= s1_outer_r_in;

         s2_test_ff  <= s1_test_ff;
         s2_done_ff  <= s1_done_ff;
         s2_x_ff     <= s1_x_ff;
         s2_y_ff     <= s1_y_ff;
         s2_dx_sq_ff <= 24'(s1_dx_ff) * 24'(s1_dx_ff);
         s2_dy_sq_ff <= 24'(s1_dy_ff) * 24'(s1_dy_ff);
         s2_row_ff   <= 25'(s1_y_ff) * 25'(row_pitch_ff);

         rsp_data_ff <= rsp_data_in;
      end
   end

   // Swap in the new ring edges as the load passes into stage 2, so items of the
   // previous shape still ahead of it compare against the old edges.
   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff && s1_load_ff) begin
         inner_sq_ff <= 26'(s1_inner_r_ff) * 26'(s1_inner_r_ff);
         outer_sq_ff <= 26'(s1_outer_r_ff) * 26'(s1_outer_r_ff);
      end
   end

   always_comb begin
      dist_sq                   = 26'(s2_dx_sq_ff) + 26'(s2_dy_sq_ff);
      rsp_data_in.paint         = s2_test_ff && (dist_sq >= inner_sq_ff)
                                  && (dist_sq <= outer_sq_ff);
      rsp_data_in.pixel_x       = s2_x_ff;
      rsp_data_in.pixel_y       = s2_y_ff;
      rsp_data_in.pixel_address = 24'(s2_row_ff + 25'(s2_x_ff));
      rsp_data_in.scan_done     = s2_done_ff;
   end

   // ---------------------------------------------------------------- checks
   // A running scan stays inside its window.
   assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (scan_x_ff <= win_x_last_ff) && (scan_y_ff <= win_y_last_ff)
                    && (scan_y_ff >= win_y_first_ff))
      else $error("scan position left its window");

   // Input backpressure only comes from a held result.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid_ff && !rsp_ready)
      else $error("input stalled without a held result");

   // Stepping onto the last pixel ends the scan.
   assert property (@(posedge clock) disable iff (reset)
      accept && (req_data.opcode == drps_pkg::OP_STEP) && active_ff && last_row && last_col
      |=> !active_ff && s1_done_ff && s1_test_ff)
      else $error("last pixel did not end the scan");

   // Only a tested pixel can be painted.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.paint) |-> $past(s2_test_ff) || !$past(advance))
      else $error("paint reported for an untested item");

endmodule
